[hw/rtl/edc_pkg.sv]
package edc_pkg;

  // Input opcodes
  localparam logic [1:0] OP_KEYWORD = 2'd0;
  localparam logic [1:0] OP_SEARCH  = 2'd1;
  localparam logic [1:0] OP_FINISH  = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_LATE_KW  = 2'd2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] char_code;
  } item_t;

  typedef struct packed {
    logic [6:0] distance;
    logic [1:0] status;
  } result_t;

  // What travels down the cell chain each cycle
  typedef enum logic [1:0] {
    TOK_NONE,
    TOK_SEARCH,
    TOK_FINISH
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [7:0] char_code;
  } tok_t;

endpackage

[hw/rtl/edc_cell.sv]
module edc_cell #(
  parameter int INDEX = 1,
  parameter int CW    = 7,
  parameter int IW    = 6
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            kw_we,
  input  logic [IW-1:0]   kw_idx,
  input  logic [7:0]      kw_char,
  input  edc_pkg::tok_t   tok_in,
  input  logic [CW-1:0]   left_in,
  input  logic [CW-1:0]   diag_in,
  input  logic [CW-1:0]   dist_in,
  output edc_pkg::tok_t   tok_out,
  output logic [CW-1:0]   left_out,
  output logic [CW-1:0]   diag_out,
  output logic [CW-1:0]   dist_out
);
  import edc_pkg::*;

  logic          kw_valid;
  logic [7:0]    kw_byte;
  logic [CW-1:0] cost;
  logic [CW-1:0] cost_next;
  logic [CW-1:0] best;

  // Unit-cost recurrence: match takes the diagonal, else min of three plus one
  always_comb begin
    best = (diag_in < cost) ? diag_in : cost;
    best = (left_in < best) ? left_in : best;
    if (kw_byte == tok_in.char_code) begin
      cost_next = diag_in;
    end else begin
      cost_next = best + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    tok_out.char_code <= tok_in.char_code;
    if (rst) begin
      kw_valid     <= 1'b0;
      cost         <= CW'(INDEX);
      tok_out.kind <= TOK_NONE;
    end else begin
      tok_out.kind <= tok_in.kind;
      if (kw_we && kw_idx == IW'(INDEX - 1)) begin
        kw_valid <= 1'b1;
      end
      if (tok_in.kind == TOK_SEARCH && kw_valid) begin
        cost <= cost_next;
      end else if (tok_in.kind == TOK_FINISH) begin
        // clear this position as the finish beat passes
        cost     <= CW'(INDEX);
        kw_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (kw_we && kw_idx == IW'(INDEX - 1)) begin
      kw_byte <= kw_char;
    end
    left_out          <= kw_valid ? cost_next : left_in;
    diag_out          <= cost;
    dist_out          <= (kw_valid && tok_in.kind == TOK_FINISH) ? cost : dist_in;
  end

endmodule

[hw/rtl/edit_distance_engine_top.sv]
// A finish beat walks the whole chain of MAX_LEN cells, one cell per cycle; its
//   distance is then held until the output register is free and is registered
//   there as the result.
// Throughput: one keyword or search beat per cycle; after a finish, item_stall
//   stays high until the result is handed to the output register.
// Reset: synchronous, active high; clears lengths and flags, and sets the cost column to each cell's index.
module edit_distance_engine_top #(
  parameter int MAX_LEN = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  edc_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output edc_pkg::result_t result
);
  import edc_pkg::*;

  // Cost and length width, and keyword index width
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic [CW-1:0] kw_len;
  logic [CW-1:0] srch_len;
  logic          started;
  logic [1:0]    err;
  logic [1:0]    err_next;
  logic          draining;
  logic [1:0]    status_hold;
  logic          pend;
  logic [CW-1:0] pend_dist;
  logic          accept;
  logic          kw_take;
  logic          srch_take;
  logic          fin_take;
  logic          out_free;
  logic [CW+6:0] dist_ext;

  // Chain taps: entry 0 is driven here, entry i is the output of cell i
  tok_t          tok_c  [0:MAX_LEN];
  logic [CW-1:0] left_c [0:MAX_LEN];
  logic [CW-1:0] diag_c [0:MAX_LEN];
  logic [CW-1:0] dist_c [0:MAX_LEN];

  assign item_stall = draining;
  assign accept     = item_valid && !draining;
  assign out_free   = !result_valid || !result_stall;

  // Decode the accepted beat; the first raised flag holds until finish
  always_comb begin
    kw_take   = 1'b0;
    srch_take = 1'b0;
    fin_take  = 1'b0;
    err_next  = err;
    if (accept) begin
      case (item.opcode)
        OP_KEYWORD: begin
          if (started) begin
            if (err == ST_OK) err_next = ST_LATE_KW;
          end else if (kw_len == CW'(MAX_LEN)) begin
            if (err == ST_OK) err_next = ST_OVERFLOW;
          end else begin
            kw_take = 1'b1;
          end
        end
        OP_SEARCH: begin
          if (srch_len == CW'(MAX_LEN)) begin
            if (err == ST_OK) err_next = ST_OVERFLOW;
          end else begin
            srch_take = 1'b1;
          end
        end
        OP_FINISH: begin
          fin_take = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Column entry 0 lives here: its old value is the diagonal for cell 1, its
  // new value the left neighbor; with an empty keyword it is also the distance.
  always_comb begin
    tok_c[0].kind      = TOK_NONE;
    tok_c[0].char_code = item.char_code;
    if (srch_take) tok_c[0].kind = TOK_SEARCH;
    if (fin_take)  tok_c[0].kind = TOK_FINISH;
    left_c[0] = srch_len + CW'(1);
    diag_c[0] = srch_len;
    dist_c[0] = srch_len;
  end

  genvar g;
  generate
    for (g = 1; g <= MAX_LEN; g++) begin : g_cell
      edc_cell #(
        .INDEX (g),
        .CW    (CW),
        .IW    (IW)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .kw_we    (kw_take),
        .kw_idx   (kw_len[IW-1:0]),
        .kw_char  (item.char_code),
        .tok_in   (tok_c[g-1]),
        .left_in  (left_c[g-1]),
        .diag_in  (diag_c[g-1]),
        .dist_in  (dist_c[g-1]),
        .tok_out  (tok_c[g]),
        .left_out (left_c[g]),
        .diag_out (diag_c[g]),
        .dist_out (dist_c[g])
      );
    end
  endgenerate

  // Control: lengths, flags, drain tracking and the result handoff
  always_ff @(posedge clk) begin
    if (rst) begin
      kw_len       <= '0;
      srch_len     <= '0;
      started      <= 1'b0;
      err          <= ST_OK;
      draining     <= 1'b0;
      pend         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (fin_take) begin
        // clear for the next pair; the cells clear as the finish beat passes
        kw_len   <= '0;
        srch_len <= '0;
        started  <= 1'b0;
        err      <= ST_OK;
        draining <= 1'b1;
      end else begin
        err <= err_next;
        if (kw_take) kw_len <= kw_len + CW'(1);
        if (srch_take) begin
          srch_len <= srch_len + CW'(1);
          started  <= 1'b1;
        end
      end
      // hold the drained distance until the output register is free
      if (tok_c[MAX_LEN].kind == TOK_FINISH) begin
        pend <= 1'b1;
      end else if (pend && out_free) begin
        pend     <= 1'b0;
        draining <= 1'b0;
      end
      if (pend && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  assign dist_ext = {7'd0, pend_dist};

  always_ff @(posedge clk) begin
    if (fin_take) status_hold <= err;
    if (tok_c[MAX_LEN].kind == TOK_FINISH) pend_dist <= dist_c[MAX_LEN];
    if (pend && out_free) begin
      result.distance <= dist_ext[6:0];
      result.status   <= status_hold;
    end
  end

endmodule

[tb/tb_edit_distance_engine_top.sv]
`timescale 1ns / 100ps

module tb_edit_distance_engine_top;
  import edc_pkg::*;

  localparam int MAX_LEN = 64;
  localparam int CYCLE_LIMIT = 500_000;
  // Opcode 3 is left unused by the block: it must be swallowed without a result.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  edit_distance_engine_top #(
    .MAX_LEN(MAX_LEN)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Traffic shaping knobs, set by the test tasks.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_left = 0;

  int items_sent = 0;
  int error_count = 0;
  int cycle_count = 0;

  // Distance predictor state: keyword bytes, string lengths and the cost column.
  logic [7:0] kw_bytes [MAX_LEN];
  int         kw_len;
  int         srch_len;
  int         cost_col [MAX_LEN + 1];
  bit         srch_begun;
  logic [1:0] pair_flag;

  result_t pending_results [$];
  result_t want_beat;

  function automatic void clear_pair();
    for (int i = 0; i <= MAX_LEN; i++) cost_col[i] = i;
    kw_len = 0;
    srch_len = 0;
    srch_begun = 1'b0;
    pair_flag = ST_OK;
  endfunction

  // Keep the first flag of a pair; later ones are lost.
  function automatic void raise_flag(input logic [1:0] code);
    if (pair_flag == ST_OK) pair_flag = code;
  endfunction

  function automatic void step_distance(input logic [1:0] op, input logic [7:0] ch);
    int diag;
    int up;
    int left;
    int best;
    result_t want;
    case (op)
      OP_KEYWORD: begin
        if (srch_begun) begin
          raise_flag(ST_LATE_KW);
        end else if (kw_len >= MAX_LEN) begin
          raise_flag(ST_OVERFLOW);
        end else begin
          kw_bytes[kw_len] = ch;
          kw_len++;
        end
      end
      OP_SEARCH: begin
        if (srch_len >= MAX_LEN) begin
          raise_flag(ST_OVERFLOW);
        end else begin
          srch_begun = 1'b1;
          srch_len++;
          diag = cost_col[0];
          cost_col[0] = srch_len;
          for (int i = 1; i <= kw_len; i++) begin
            up = cost_col[i];
            left = cost_col[i - 1];
            if (kw_bytes[i - 1] == ch) begin
              cost_col[i] = diag;
            end else begin
              best = (diag < up) ? diag : up;
              best = (left < best) ? left : best;
              cost_col[i] = best + 1;
            end
            diag = up;
          end
        end
      end
      OP_FINISH: begin
        want.distance = 7'(cost_col[kw_len]);
        want.status = pair_flag;
        pending_results = {pending_results, want};
        clear_pair();
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
    error_count++;
  endtask

  // Offer one beat, idling first at random, and hold it until accepted.
  task automatic send_beat(input logic [1:0] op, input logic [7:0] ch);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      item <= '{opcode: 2'($urandom), char_code: 8'($urandom)};
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= '{opcode: op, char_code: ch};
    do @(posedge clk); while (item_stall);
    step_distance(op, ch);
    if (op != OP_UNUSED) items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_char(input logic [31:0] alpha, input bit narrow);
    int sel;
    sel = $urandom_range(3);
    return narrow ? alpha[8 * sel +: 8] : 8'($urandom);
  endfunction

  // Mostly short strings; now and then empty or around the length limit, up to two past it.
  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 4) return $urandom_range(MAX_LEN - 3, MAX_LEN + 2);
    if (r < 12) return 0;
    return $urandom_range(1, 12);
  endfunction

  // One keyword/search pair closed by a finish. A broken pair gets stray
  // beats of any opcode after its search part.
  task automatic send_pair(input bit well_formed);
    logic [7:0] kw [$];
    logic [31:0] alpha;
    bit narrow;
    int n;
    int r;
    alpha = $urandom;
    narrow = $urandom_range(3) != 0;
    n = pick_len();
    for (int i = 0; i < n; i++) begin
      kw = {kw, pick_char(alpha, narrow)};
      send_beat(OP_KEYWORD, kw[i]);
    end
    if ($urandom_range(1)) begin
      // Search string as an edited copy of the keyword.
      foreach (kw[i]) begin
        r = $urandom_range(9);
        if (r == 1) send_beat(OP_SEARCH, pick_char(alpha, narrow));
        if (r == 2) send_beat(OP_SEARCH, pick_char(alpha, narrow));
        else if (r != 0) send_beat(OP_SEARCH, kw[i]);
      end
    end else begin
      n = pick_len();
      for (int i = 0; i < n; i++) send_beat(OP_SEARCH, pick_char(alpha, narrow));
    end
    if (!well_formed) begin
      repeat ($urandom_range(1, 6)) send_beat(2'($urandom_range(3)), 8'($urandom));
    end
    send_beat(OP_FINISH, 8'($urandom));
  endtask

  task automatic test_basic_cases();
    send_beat(OP_FINISH, 8'h00);          // both strings empty
    send_beat(OP_KEYWORD, 8'h00);
    send_beat(OP_KEYWORD, 8'hFF);
    send_beat(OP_FINISH, 8'hFF);          // empty search: keyword length
    send_beat(OP_SEARCH, 8'hFF);
    send_beat(OP_FINISH, 8'h00);          // empty keyword: search length
    send_beat(OP_KEYWORD, 8'hFF);
    send_beat(OP_SEARCH, 8'hFF);
    send_beat(OP_FINISH, 8'h5A);          // exact match
    send_beat(OP_KEYWORD, 8'h00);
    send_beat(OP_UNUSED, 8'hFF);          // unused opcode, no result
    send_beat(OP_SEARCH, 8'hFF);
    send_beat(OP_FINISH, 8'h00);          // substitution
    send_beat(OP_KEYWORD, 8'h61);
    send_beat(OP_KEYWORD, 8'h62);
    send_beat(OP_SEARCH, 8'h62);
    send_beat(OP_FINISH, 8'h00);          // deletion
    send_beat(OP_KEYWORD, 8'h78);
    send_beat(OP_SEARCH, 8'h78);
    send_beat(OP_KEYWORD, 8'h79);         // late keyword byte
    send_beat(OP_SEARCH, 8'h79);          // insertion after the flag
    send_beat(OP_FINISH, 8'h00);
  endtask

  task automatic test_length_limits();
    // Full-length disjoint strings: distance reaches its maximum.
    repeat (MAX_LEN) send_beat(OP_KEYWORD, 8'h00);
    repeat (MAX_LEN) send_beat(OP_SEARCH, 8'hFF);
    send_beat(OP_FINISH, 8'h00);
    // Keyword overflow.
    repeat (MAX_LEN + 1) send_beat(OP_KEYWORD, 8'($urandom_range(1)));
    repeat (3) send_beat(OP_SEARCH, 8'($urandom_range(1)));
    send_beat(OP_FINISH, 8'h00);
    // Search overflow, then a late keyword: the overflow flag stays.
    send_beat(OP_KEYWORD, 8'h41);
    repeat (MAX_LEN + 1) send_beat(OP_SEARCH, 8'($urandom_range(8'h40, 8'h42)));
    send_beat(OP_KEYWORD, 8'h41);
    send_beat(OP_FINISH, 8'h00);
    // Late keyword first, then search overflow: the late flag stays.
    send_beat(OP_KEYWORD, 8'h41);
    send_beat(OP_SEARCH, 8'h41);
    send_beat(OP_KEYWORD, 8'h42);
    repeat (MAX_LEN) send_beat(OP_SEARCH, 8'h41);
    send_beat(OP_FINISH, 8'h00);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n);
    int target;
    target = items_sent + n;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    while (items_sent < target) send_pair($urandom_range(99) < 80);
  endtask

  // Hold the output for a long stretch while beats keep coming, so the
  // block backs up and stalls its input.
  task automatic test_output_hold_off();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_left = 400;
    repeat (8) send_pair(1'b1);
  endtask

  // Pause the sender until every result is home, then carry on.
  task automatic test_drain_pause();
    send_idle_pct = 0;
    recv_stall_pct = 20;
    send_pair(1'b1);
    wait_drained();
    send_pair(1'b1);
    send_pair(1'b0);
  endtask

  // Receiver: forced hold-off first, otherwise random stalls.
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      result_stall <= 1'b1;
      hold_off_left--;
    end else begin
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Compare each accepted result beat with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, distance", result.distance, -1);
      end else begin
        want_beat = pending_results.pop_front();
        if (result.distance !== want_beat.distance)
          report_mismatch("distance", result.distance, want_beat.distance);
        if (result.status !== want_beat.status)
          report_mismatch("status", result.status, want_beat.status);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    clear_pair();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_basic_cases();
    test_length_limits();
    test_random_traffic(0, 0, 50);
    test_random_traffic(69, 0, 50);
    test_random_traffic(0, 69, 50);
    test_random_traffic(36, 36, 50);
    test_output_hold_off();
    test_drain_pause();

    wait_drained();
    repeat (MAX_LEN + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/edc_pkg.sv
hw/rtl/edc_cell.sv
hw/rtl/edit_distance_engine_top.sv
tb/tb_edit_distance_engine_top.sv
